>>> hw/rtl/clps_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the character LCD parallel sequencer.
// Used by every module of the block but clps_store; depends on nothing.
package clps_pkg;

  localparam int unsigned Rows    = 2;
  localparam int unsigned Columns = 16;

  localparam logic [7:0] DdramSet   = 8'h80;
  localparam logic [7:0] Row1Base   = 8'h00;
  localparam logic [7:0] Row2Base   = 8'h40;
  localparam logic [3:0] InitLastStep = 4'd11;

  typedef enum logic [2:0] {
    OpTick    = 3'd0,
    OpInit    = 3'd1,
    OpCommand = 3'd2,
    OpCursor  = 3'd3,
    OpChar    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ActIdle    = 2'd0,
    ActInit    = 2'd1,
    ActCommand = 2'd2,
    ActWrite   = 2'd3
  } act_e;

  typedef struct packed {
    logic       status;
    logic       rs_level;
    logic       rw_level;
    logic       en_level;
    logic [7:0] data_bus;
    logic       busy_res;
    logic       init_done;
  } result_t;

  function automatic logic [7:0] init_cmd(input logic [2:0] k);
    logic [7:0] cmd;
    case (k)
      3'd0:    cmd = 8'h38;
      3'd1:    cmd = 8'h08;
      3'd2:    cmd = 8'h02;
      3'd3:    cmd = 8'h01;
      3'd4:    cmd = 8'h06;
      default: cmd = 8'h0E;
    endcase
    return cmd;
  endfunction

endpackage

>>> hw/rtl/char_lcd_parallel_sequencer.sv
`timescale 1ns / 1ps
// Top level of the character LCD parallel sequencer.
// Depends on clps_pkg, clps_seq (with clps_store) and clps_outbuf.

// One transaction in gives exactly one result transaction out. A new input
// transaction is taken every clock cycle while in_ready_o is high; its
// result is registered in a two-entry output stage, so input keeps flowing
// for one more transaction while the consumer stalls. Pin levels in each
// result are those after the transaction was applied. The string buffer
// is a synchronous memory whose read port is always aimed at the current
// write index, so a character is ready in time for its tick.
module char_lcd_parallel_sequencer #(
  parameter int unsigned COLUMNS = clps_pkg::Columns
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] operation_i,
  input  logic [7:0] command_byte_i,
  input  logic [1:0] row_i,
  input  logic [4:0] column_i,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       status_o,
  output logic       rs_level_o,
  output logic       rw_level_o,
  output logic       en_level_o,
  output logic [7:0] data_bus_o,
  output logic       busy_res_o,
  output logic       init_done_o
);

  logic              fire;
  clps_pkg::result_t res;
  clps_pkg::result_t out_res;

  assign fire = in_valid_i && in_ready_o;

  clps_seq #(
    .Columns (COLUMNS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .operation_i    (operation_i),
    .command_byte_i (command_byte_i),
    .row_i          (row_i),
    .column_i       (column_i),
    .char_code_i    (char_code_i),
    .last_char_i    (last_char_i),
    .res_o          (res)
  );

  clps_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign status_o    = out_res.status;
  assign rs_level_o  = out_res.rs_level;
  assign rw_level_o  = out_res.rw_level;
  assign en_level_o  = out_res.en_level;
  assign data_bus_o  = out_res.data_bus;
  assign busy_res_o  = out_res.busy_res;
  assign init_done_o = out_res.init_done;

endmodule

>>> hw/rtl/clps_store.sv
`timescale 1ns / 1ps
// String buffer memory: one write port and one read port with registered read data.
// Stand-alone; sized by the Depth parameter handed down from the sequencer.
module clps_store #(
  parameter int unsigned Depth = 32,
  parameter int unsigned IdxW  = $clog2(Depth)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  logic [7:0]      wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output logic [7:0]      rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/clps_seq.sv
`timescale 1ns / 1ps
// Sequencer core: request decode, half-step pin sequencing and string buffer control.
// Depends on clps_pkg and instantiates clps_store.
module clps_seq #(
  parameter int unsigned Columns = clps_pkg::Columns
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [2:0]          operation_i,
  input  logic [7:0]          command_byte_i,
  input  logic [1:0]          row_i,
  input  logic [4:0]          column_i,
  input  logic [7:0]          char_code_i,
  input  logic                last_char_i,
  output clps_pkg::result_t   res_o
);

  localparam int unsigned Depth = clps_pkg::Rows * Columns;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  clps_pkg::act_e activity_q, activity_d;
  logic [3:0]     step_q, step_d;
  logic [7:0]     pending_q, pending_d;
  logic [CntW-1:0] length_q, length_d;
  logic [CntW-1:0] windex_q, windex_d;
  logic           init_q, init_d;
  logic           rs_q, rs_d;
  logic           en_q, en_d;
  logic [7:0]     data_q, data_d;

  logic           mem_we;
  logic [7:0]     mem_rdata;
  logic [7:0]     col_c;
  logic [7:0]     base_c;
  logic [7:0]     cursor_cmd;
  logic           busy;
  logic           ready;
  logic           status;
  logic [2:0]     init_k;

  clps_store #(
    .Depth (Depth),
    .IdxW  (IdxW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (length_q[IdxW-1:0]),
    .wdata_i (char_code_i),
    .raddr_i (windex_q[IdxW-1:0]),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    col_c = {3'b000, column_i};
    if (col_c == 8'd0) begin
      col_c = 8'd1;
    end else if (col_c > 8'(Columns)) begin
      col_c = 8'(Columns);
    end
    base_c     = (row_i <= 2'd1) ? clps_pkg::Row1Base : clps_pkg::Row2Base;
    cursor_cmd = clps_pkg::DdramSet | (base_c + col_c - 8'd1);
  end

  assign busy   = (activity_q != clps_pkg::ActIdle);
  assign ready  = !busy && init_q;
  assign init_k = (step_q[3:1] > 3'd5) ? 3'd5 : step_q[3:1];

  always_comb begin
    activity_d = activity_q;
    step_d     = step_q;
    pending_d  = pending_q;
    length_d   = length_q;
    windex_d   = windex_q;
    init_d     = init_q;
    rs_d       = rs_q;
    en_d       = en_q;
    data_d     = data_q;
    mem_we     = 1'b0;
    status     = 1'b0;
    if (fire_i) begin
      unique case (operation_i)
        clps_pkg::OpTick: begin
          unique case (activity_q)
            clps_pkg::ActInit: begin
              if (!step_q[0]) begin
                rs_d   = 1'b0;
                data_d = clps_pkg::init_cmd(init_k);
                en_d   = 1'b1;
                step_d = step_q + 4'd1;
              end else begin
                en_d = 1'b0;
                if (step_q >= clps_pkg::InitLastStep) begin
                  activity_d = clps_pkg::ActIdle;
                  step_d     = 4'd0;
                  init_d     = 1'b1;
                end else begin
                  step_d = step_q + 4'd1;
                end
              end
            end
            clps_pkg::ActCommand: begin
              if (step_q == 4'd0) begin
                rs_d   = 1'b0;
                data_d = pending_q;
                en_d   = 1'b1;
                step_d = 4'd1;
              end else begin
                en_d       = 1'b0;
                activity_d = clps_pkg::ActIdle;
                step_d     = 4'd0;
              end
            end
            clps_pkg::ActWrite: begin
              case (step_q[1:0])
                2'd0: begin
                  if (windex_q == CntW'(Columns)) begin
                    rs_d   = 1'b0;
                    data_d = clps_pkg::DdramSet | clps_pkg::Row2Base;
                    en_d   = 1'b1;
                  end
                  step_d = 4'd1;
                end
                2'd1: begin
                  en_d   = 1'b0;
                  step_d = 4'd2;
                end
                2'd2: begin
                  rs_d     = 1'b1;
                  data_d   = mem_rdata;
                  en_d     = 1'b1;
                  windex_d = windex_q + CntW'(1);
                  step_d   = 4'd3;
                end
                default: begin
                  en_d = 1'b0;
                  if (windex_q >= length_q || windex_q >= CntW'(Depth)) begin
                    activity_d = clps_pkg::ActIdle;
                    step_d     = 4'd0;
                    length_d   = '0;
                    windex_d   = '0;
                  end else begin
                    step_d = 4'd0;
                  end
                end
              endcase
            end
            default: begin
            end
          endcase
        end
        clps_pkg::OpInit: begin
          if (busy) begin
            status = 1'b1;
          end else begin
            activity_d = clps_pkg::ActInit;
            step_d     = 4'd0;
          end
        end
        clps_pkg::OpCommand, clps_pkg::OpCursor: begin
          if (!ready) begin
            status = 1'b1;
          end else begin
            pending_d  = (operation_i == clps_pkg::OpCommand) ? command_byte_i : cursor_cmd;
            activity_d = clps_pkg::ActCommand;
            step_d     = 4'd0;
          end
        end
        clps_pkg::OpChar: begin
          if (!ready) begin
            status = 1'b1;
          end else begin
            if (length_q < CntW'(Depth)) begin
              mem_we   = 1'b1;
              length_d = length_q + CntW'(1);
            end
            if (last_char_i) begin
              activity_d = clps_pkg::ActWrite;
              step_d     = 4'd0;
              windex_d   = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      activity_q <= clps_pkg::ActIdle;
      step_q     <= 4'd0;
      pending_q  <= 8'd0;
      length_q   <= '0;
      windex_q   <= '0;
      init_q     <= 1'b0;
      rs_q       <= 1'b0;
      en_q       <= 1'b0;
      data_q     <= 8'd0;
    end else begin
      activity_q <= activity_d;
      step_q     <= step_d;
      pending_q  <= pending_d;
      length_q   <= length_d;
      windex_q   <= windex_d;
      init_q     <= init_d;
      rs_q       <= rs_d;
      en_q       <= en_d;
      data_q     <= data_d;
    end
  end

  always_comb begin
    res_o.status    = status;
    res_o.rs_level  = rs_d;
    res_o.rw_level  = 1'b0;
    res_o.en_level  = en_d;
    res_o.data_bus  = data_d;
    res_o.busy_res  = (activity_d != clps_pkg::ActIdle);
    res_o.init_done = init_d;
  end

`ifndef ASSERT_OFF
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    length_q <= CntW'(Depth))
    else $error("string length exceeds buffer depth");

  a_windex_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    activity_q == clps_pkg::ActWrite |-> windex_q <= length_q)
    else $error("write index ran past string length");

  a_read_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && operation_i == clps_pkg::OpTick && activity_q == clps_pkg::ActWrite
    && step_q[1:0] == 2'd2 |-> windex_q < length_q)
    else $error("character read from an unwritten buffer entry");

  a_init_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    activity_q == clps_pkg::ActInit |-> step_q <= clps_pkg::InitLastStep)
    else $error("init step out of range");

  a_init_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |=> init_q)
    else $error("init done flag dropped");
`endif

endmodule

>>> hw/rtl/clps_outbuf.sv
`timescale 1ns / 1ps
// Two-entry output stage (output register plus skid register) for result transactions.
// Depends on clps_pkg for the result type.
module clps_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  clps_pkg::result_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output clps_pkg::result_t out_data_o
);

  logic              main_valid_q, main_valid_d;
  logic              skid_valid_q, skid_valid_d;
  clps_pkg::result_t main_q, skid_q;
  logic              load_main, load_skid, move;

  assign in_ready_o = !skid_valid_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    load_main    = 1'b0;
    load_skid    = 1'b0;
    move         = 1'b0;
    if (skid_valid_q) begin
      if (out_ready_i) begin
        move         = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (in_valid_i) begin
      if (!main_valid_q || out_ready_i) begin
        load_main    = 1'b1;
        main_valid_d = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (out_ready_i) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      main_q <= skid_q;
    end else if (load_main) begin
      main_q <= in_data_i;
    end
    if (load_skid) begin
      skid_q <= in_data_i;
    end
  end

  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

endmodule
